// ===== rtl/core/stepper_command_pulse_controller_assert.svh =====
// Assertion macros for the stepper command and pulse controller.
// Included by the top level; depends on nothing else.
`ifndef STEPPER_COMMAND_PULSE_CONTROLLER_ASSERT_SVH
`define STEPPER_COMMAND_PULSE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scpc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SCPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scpc: next-cycle check failed");

`endif

// ===== rtl/core/scpc_pkg.sv =====
// Shared types, character codes and arithmetic helpers for the stepper
// command and pulse controller. No dependencies.
package scpc_pkg;

    // Word widths.
    localparam int CHAR_W  = 8;
    localparam int NUM_W   = 16;
    localparam int CSEL_W  = 3;
    localparam int OUT_W   = 48;

    // Reset and setup values.
    localparam logic [NUM_W-1:0]  SETUP_PERIOD  = 16'd9999;
    localparam logic [NUM_W-1:0]  SETUP_MATCH_B = 16'd5;
    localparam logic [NUM_W-1:0]  WALK_STEPS    = 16'd1000;
    localparam logic [CSEL_W-1:0] RESET_CSEL    = 3'd2;

    // Reciprocal of ten for 16-bit operands: q = (x * 52429) >> 19.
    localparam logic [NUM_W-1:0] DIV10_MUL   = 16'd52429;
    localparam int               DIV10_SHIFT = 19;

    // Item kinds on the input user field.
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
    localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
    localparam logic [CHAR_W-1:0] CH_L     = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_P     = 8'h70;
    localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
    localparam logic [CHAR_W-1:0] CH_T     = 8'h74;
    localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
    localparam logic [CHAR_W-1:0] CH_W     = 8'h77;

    // Result word, packed from the lowest bit up (last member is bit 0).
    typedef struct packed {
        logic             pad;
        logic [NUM_W-1:0] entry_value;
        logic [NUM_W-1:0] steps_left;
        logic             drive_off;
        logic             direction;
        logic             strobe_level;
        logic             step_pulse;
        logic             sent_unknown;
        logic             sent_backspace;
        logic [CHAR_W-1:0] echo_char;
        logic             echo_valid;
    } t_result;

    // Unsigned divide by ten through a reciprocal multiply.
    function automatic logic [NUM_W-1:0] div10(input logic [NUM_W-1:0] x);
        logic [2*NUM_W-1:0] prod;
        prod = {{NUM_W{1'b0}}, x} * {{NUM_W{1'b0}}, DIV10_MUL};
        return {{(DIV10_SHIFT-NUM_W){1'b0}}, prod[2*NUM_W-1:DIV10_SHIFT]};
    endfunction

    // Entry times ten plus a digit, wrapping modulo 2^16.
    function automatic logic [NUM_W-1:0] mul10_add(input logic [NUM_W-1:0] x,
                                                   input logic [3:0] d);
        logic [NUM_W-1:0] x8;
        logic [NUM_W-1:0] x2;
        x8 = x << 3;
        x2 = x << 1;
        return x8 + x2 + {{(NUM_W-4){1'b0}}, d};
    endfunction

endpackage

// ===== rtl/core/stepper_command_pulse_controller.sv =====
// Top level of the stepper command and pulse controller: input register,
// command and timer logic, result register. Depends on scpc_pkg and the
// assertion header stepper_command_pulse_controller_assert.svh.
//
//  channel  | dir | tdata                         | tuser
//  ---------+-----+-------------------------------+------------------------
//  s_axis   | in  | char_code[7:0]                | opcode (0 char, 1 tick)
//  m_axis   | out | result word, 48 bits (below)  | none
//
// One word is accepted per clock while m_axis does not stall. A word is
// held in the input register, is decoded there against the controller
// state and lands in the result register. The state update and the
// single decode stage set the rate of one word per clock. A stall on
// m_axis holds the result register and then the input register;
// s_axis_tready drops only when both are full.
// Reset is synchronous and active low and restores the valid flags and all controller state.
module stepper_command_pulse_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [scpc_pkg::CHAR_W-1:0]   s_axis_tdata,   // [7:0] char_code
    input  logic                          s_axis_tuser,   // [0] opcode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] echo_valid, [8:1] echo_char, [9] sent_backspace, [10] sent_unknown,
    // [11] step_pulse, [12] strobe_level, [13] direction, [14] drive_off,
    // [30:15] steps_left, [46:31] entry_value, [47] zero
    output logic [scpc_pkg::OUT_W-1:0]    m_axis_tdata
);
    import scpc_pkg::*;

    // Input register.
    logic              r_in_valid;
    logic              r_in_op;
    logic [CHAR_W-1:0] r_in_char;

    // Result register.
    logic    r_out_valid;
    t_result r_out;
    t_result n_res;

    // Controller state.
    logic [NUM_W-1:0]  r_entry,  n_entry;
    logic              r_active, n_active;
    logic [NUM_W-1:0]  r_steps,  n_steps;
    logic              r_dir,    n_dir;
    logic              r_off,    n_off;
    logic              r_strobe, n_strobe;
    logic              r_phase,  n_phase;
    logic [NUM_W-1:0]  r_timer,  n_timer;
    logic [NUM_W-1:0]  r_period, n_period;
    logic [NUM_W-1:0]  r_match_b, n_match_b;
    logic [CSEL_W-1:0] r_csel,   n_csel;

    logic advance;
    logic fire;

    // Handshake: the result register frees when empty or taken downstream.
    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // Decode of one word against the current state.
    always_comb begin
        n_entry   = r_entry;
        n_active  = r_active;
        n_steps   = r_steps;
        n_dir     = r_dir;
        n_off     = r_off;
        n_strobe  = r_strobe;
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_period  = r_period;
        n_match_b = r_match_b;
        n_csel    = r_csel;
        n_res     = '0;

        if (r_in_op == OP_CHAR) begin
            if (r_in_char != CH_NUL) begin
                n_res.echo_valid = 1'b1;
                n_res.echo_char  = r_in_char;
                if (r_in_char == CH_BS) begin
                    n_entry = div10(r_entry);
                end else if (r_in_char inside {[CH_0:CH_9]}) begin
                    // A digit after a command character, or after reset, starts a new number.
                    n_entry  = r_active ? mul10_add(r_entry, r_in_char[3:0])
                                        : {{(NUM_W-4){1'b0}}, r_in_char[3:0]};
                    n_active = 1'b1;
                end else begin
                    n_res.sent_backspace = 1'b1;
                    n_active = 1'b0;
                    case (r_in_char)
                        CH_SPACE: n_steps = '0;
                        CH_A: begin
                            n_timer  = '0;
                            n_period = r_entry;
                        end
                        CH_B: n_match_b = r_entry;
                        CH_C: begin
                            n_csel    = r_entry[CSEL_W-1:0];
                            n_timer   = '0;
                            n_period  = SETUP_PERIOD;
                            n_match_b = SETUP_MATCH_B;
                        end
                        CH_D: n_off = 1'b1;
                        CH_E: n_off = 1'b0;
                        CH_L: n_dir = 1'b1;
                        CH_R: n_dir = 1'b0;
                        CH_P, CH_U: begin
                        end
                        CH_W: begin
                            n_entry = WALK_STEPS;
                            n_steps = WALK_STEPS;
                        end
                        CH_S: n_steps = r_entry;
                        CH_T: begin
                            n_strobe = r_phase;
                            n_phase  = !r_phase;
                        end
                        default: n_res.sent_unknown = 1'b1;
                    endcase
                end
            end
        end else if (r_csel != '0) begin
            // Timer tick: clear on compare match and issue a step if any remain.
            if (r_timer == r_period) begin
                n_timer = '0;
                if (r_steps != '0) begin
                    n_steps          = r_steps - 1'b1;
                    n_strobe         = 1'b0;
                    n_res.step_pulse = 1'b1;
                end
            end else begin
                n_timer = r_timer + 1'b1;
            end
        end

        n_res.strobe_level = n_strobe;
        n_res.direction    = n_dir;
        n_res.drive_off    = n_off;
        n_res.steps_left   = n_steps;
        n_res.entry_value  = n_entry;
    end

    // Pipeline registers and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_entry     <= '0;
            r_active    <= 1'b0;
            r_steps     <= '0;
            r_dir       <= 1'b0;
            r_off       <= 1'b0;
            r_strobe    <= 1'b0;
            r_phase     <= 1'b0;
            r_timer     <= '0;
            r_period    <= SETUP_PERIOD;
            r_match_b   <= SETUP_MATCH_B;
            r_csel      <= RESET_CSEL;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_entry   <= n_entry;
                r_active  <= n_active;
                r_steps   <= n_steps;
                r_dir     <= n_dir;
                r_off     <= n_off;
                r_strobe  <= n_strobe;
                r_phase   <= n_phase;
                r_timer   <= n_timer;
                r_period  <= n_period;
                r_match_b <= n_match_b;
                r_csel    <= n_csel;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_char <= s_axis_tdata;
        end
        if (fire) begin
            r_out <= n_res;
        end
    end

`include "stepper_command_pulse_controller_assert.svh"

    // A step pulse never comes with an echoed character.
    `SCPC_ASSERT_NOW(a_pulse_no_echo, i_clk, i_rst_n,
        r_out_valid && r_out.step_pulse, !r_out.echo_valid)
    // An unknown command always comes with a backspace and an echo in the same result word.
    `SCPC_ASSERT_NOW(a_unknown_has_bs, i_clk, i_rst_n,
        r_out_valid && r_out.sent_unknown, r_out.sent_backspace && r_out.echo_valid)
    // A stopped timer ignores ticks.
    `SCPC_ASSERT_NEXT(a_stopped_timer, i_clk, i_rst_n,
        fire && (r_in_op == OP_TICK) && (r_csel == '0), $stable(r_timer))
    // Each issued pulse takes exactly one step off the count.
    `SCPC_ASSERT_NEXT(a_pulse_counts, i_clk, i_rst_n,
        fire && n_res.step_pulse, r_steps == $past(r_steps) - 1'b1)

endmodule
